@@ sv/csu_pkg.sv @@
`default_nettype none
package csu_pkg;

  localparam int MAX_SEMAPHORES = 8;
  localparam int QUEUE_DEPTH    = 8;
  localparam int PID_BITS       = 4;
  localparam int MAX_RESULTS    = 8;

  localparam int PID_W   = (PID_BITS < 4) ? PID_BITS : 4;
  localparam int SLOT_W  = (MAX_SEMAPHORES > 1) ? $clog2(MAX_SEMAPHORES) : 1;
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LIVE_W  = $clog2(MAX_SEMAPHORES + 1);
  localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
  localparam int WQ_DEPTH = MAX_SEMAPHORES * QUEUE_DEPTH;
  localparam int WQ_AW   = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
  localparam int ENTRY_W = 16 + PID_W;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_GET     = 2'd2,
    ACT_GIVE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_QFULL    = 3'd4,
    ST_RELEASED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DECIDE,
    S_REL_RD,
    S_REL_CHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rel_rd;
    logic rel_step;
    logic fin;
  } csu_cmd_t;

  typedef struct packed {
    logic go_rel;
    logic covers;
    logic more;
    logic out_free;
    logic pend_valid;
  } csu_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sh7fff;
    if (v < -17'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp01(input logic signed [15:0] v);
    if (v > 16'sd1) return 16'sd1;
    if (v < 16'sd0) return 16'sd0;
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/csu_in_if.sv @@
`default_nettype none
interface csu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        sem_id;
  logic signed [15:0] amount;
  logic               binary_mode;
  logic [3:0]         caller_pid;

  modport source (output valid, action, sem_id, amount, binary_mode, caller_pid,
                  input ready);
  modport sink (input valid, action, sem_id, amount, binary_mode, caller_pid,
                output ready);
endinterface
`default_nettype wire

@@ sv/csu_out_if.sv @@
`default_nettype none
interface csu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] result_id;
  logic [3:0]  released_pid;
  logic        last;

  modport source (output valid, status, result_id, released_pid, last, input ready);
  modport sink (input valid, status, result_id, released_pid, last, output ready);
endinterface
`default_nettype wire

@@ sv/csu_ram.sv @@
`default_nettype none
module csu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/csu_ctrl.sv @@
`default_nettype none
module csu_ctrl
  import csu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire csu_stat_t stat,
  output csu_cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = stat.go_rel ? S_REL_RD : S_FIN;
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_next = S_REL_CHK;
      end
      S_REL_CHK: begin
        // hold while an earlier release still waits for the output register
        if (!stat.covers) begin
          state_next = S_FIN;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.rel_step = 1'b1;
          state_next   = stat.more ? S_REL_RD : S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/csu_dp.sv @@
`default_nettype none
module csu_dp
  import csu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csu_cmd_t           cmd,
  output csu_stat_t               stat,
  input  wire logic [1:0]         action,
  input  wire logic [15:0]        sem_id,
  input  wire logic signed [15:0] amount,
  input  wire logic               binary_mode,
  input  wire logic [3:0]         caller_pid,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [15:0]             result_id,
  output logic [3:0]              released_pid,
  output logic                    last
);
  // latched transaction
  action_t            r_action;
  logic [15:0]        r_id;
  logic signed [15:0] r_amt;
  logic               r_bin;
  logic [PID_W-1:0]   r_pid;

  // semaphore table
  logic [MAX_SEMAPHORES-1:0] slot_valid;
  logic [15:0]               slot_id     [MAX_SEMAPHORES];
  logic signed [15:0]        slot_count  [MAX_SEMAPHORES];
  logic                      slot_binary [MAX_SEMAPHORES];
  logic [HEAD_W-1:0]         queue_head  [MAX_SEMAPHORES];
  logic [FILL_W-1:0]         queue_fill  [MAX_SEMAPHORES];
  logic [15:0]               next_id;
  logic [LIVE_W-1:0]         live_count;

  logic [SLOT_W-1:0] sel;
  status_t           res_status;
  logic [15:0]       res_id;
  logic              go_rel;
  logic              pend_valid;
  logic [PID_W-1:0]  pend_pid;
  logic [NRES_W-1:0] nrel;

  // lookup over the table
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic              hit, free_hit;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int k = MAX_SEMAPHORES - 1; k >= 0; k--) begin
      if (slot_valid[k] && slot_id[k] == r_id) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(k);
      end
      if (!slot_valid[k]) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  logic signed [15:0] h_count, amt_eff, give_cnt;
  logic signed [16:0] get_diff;
  logic [FILL_W-1:0]  h_fill;
  logic [HEAD_W:0]    pos_sum;
  logic [HEAD_W-1:0]  pos;
  logic [15:0]        id_inc;

  always_comb begin
    h_count  = slot_count[hit_idx];
    h_fill   = queue_fill[hit_idx];
    amt_eff  = slot_binary[hit_idx] ? clamp01(r_amt) : r_amt;
    get_diff = {h_count[15], h_count} - {amt_eff[15], amt_eff};
    give_cnt = sat16({h_count[15], h_count} + {amt_eff[15], amt_eff});
    if (slot_binary[hit_idx]) give_cnt = clamp01(give_cnt);
    pos_sum  = {1'b0, queue_head[hit_idx]} + (HEAD_W + 1)'(h_fill);
    if (pos_sum >= (HEAD_W + 1)'(QUEUE_DEPTH)) pos_sum = pos_sum - (HEAD_W + 1)'(QUEUE_DEPTH);
    pos      = pos_sum[HEAD_W-1:0];
    id_inc   = next_id + 16'd1;
    if (id_inc == 16'd0) id_inc = 16'd1;
  end

  // wait queue storage
  logic               wq_we;
  logic [WQ_AW-1:0]   wq_waddr, wq_raddr;
  logic [ENTRY_W-1:0] wq_rdata;

  assign wq_we    = cmd.exec && r_action == ACT_GET && hit && get_diff < 0 &&
                    h_fill < FILL_W'(QUEUE_DEPTH);
  assign wq_waddr = WQ_AW'(32'(hit_idx) * QUEUE_DEPTH + 32'(pos));
  assign wq_raddr = WQ_AW'(32'(sel) * QUEUE_DEPTH + 32'(queue_head[sel]));

  csu_ram #(.WIDTH(ENTRY_W), .DEPTH(WQ_DEPTH)) u_wq (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata ({r_pid, amt_eff}),
    .re    (cmd.rel_rd),
    .raddr (wq_raddr),
    .rdata (wq_rdata)
  );

  // release step
  logic signed [15:0] s_count, ha, rel_cnt;
  logic signed [16:0] rel_diff;
  logic [FILL_W-1:0]  fill_dec;
  logic [NRES_W-1:0]  nrel_inc;
  logic [HEAD_W-1:0]  head_inc;

  always_comb begin
    s_count  = slot_count[sel];
    ha       = wq_rdata[15:0];
    rel_diff = {s_count[15], s_count} - {ha[15], ha};
    rel_cnt  = sat16(rel_diff);
    if (slot_binary[sel]) rel_cnt = clamp01(rel_cnt);
    fill_dec = queue_fill[sel] - FILL_W'(1);
    nrel_inc = nrel + NRES_W'(1);
    head_inc = (queue_head[sel] == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 :
               queue_head[sel] + HEAD_W'(1);
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  assign stat.go_rel     = go_rel;
  assign stat.covers     = rel_diff >= 0;
  assign stat.more       = fill_dec != '0 && nrel_inc < NRES_W'(MAX_RESULTS);
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_action <= action_t'(action);
      r_id     <= sem_id;
      r_amt    <= amount;
      r_bin    <= binary_mode;
      r_pid    <= caller_pid[PID_W-1:0];
    end

    if (cmd.exec) begin
      go_rel <= 1'b0;
      nrel   <= '0;
      res_id <= r_id;
      if (r_action == ACT_CREATE) begin
        if (live_count >= LIVE_W'(MAX_SEMAPHORES) || !free_hit) begin
          res_status <= ST_LIMIT;
          res_id     <= '0;
        end else begin
          res_status            <= ST_OK;
          res_id                <= id_inc;
          next_id               <= id_inc;
          slot_id[free_idx]     <= id_inc;
          slot_binary[free_idx] <= r_bin;
          slot_count[free_idx]  <= r_bin ? ((r_amt >= 16'sd1) ? 16'sd1 : 16'sd0) : r_amt;
          queue_head[free_idx]  <= '0;
          queue_fill[free_idx]  <= '0;
        end
      end else if (!hit) begin
        res_status <= ST_NOTFOUND;
      end else begin
        sel <= hit_idx;
        unique case (r_action)
          ACT_DESTROY: begin
            res_status           <= ST_OK;
            queue_head[hit_idx]  <= '0;
            queue_fill[hit_idx]  <= '0;
          end
          ACT_GET: begin
            if (get_diff < 0) begin
              if (h_fill >= FILL_W'(QUEUE_DEPTH)) begin
                res_status <= ST_QFULL;
              end else begin
                res_status          <= ST_QUEUED;
                queue_fill[hit_idx] <= h_fill + FILL_W'(1);
              end
            end else begin
              res_status          <= ST_OK;
              slot_count[hit_idx] <= sat16(get_diff);
            end
          end
          default: begin
            res_status          <= ST_OK;
            slot_count[hit_idx] <= give_cnt;
            go_rel              <= give_cnt > 16'sd0 && h_fill != '0;
          end
        endcase
      end
    end

    if (cmd.rel_step) begin
      slot_count[sel] <= rel_cnt;
      queue_head[sel] <= head_inc;
      queue_fill[sel] <= fill_dec;
      nrel            <= nrel_inc;
      pend_pid        <= wq_rdata[ENTRY_W-1:16];
    end

    // output register: a release is shown once the next head is decided
    if (cmd.rel_step && pend_valid) begin
      status       <= ST_RELEASED;
      result_id    <= r_id;
      released_pid <= 4'(pend_pid);
      last         <= 1'b0;
    end else if (cmd.fin) begin
      status       <= pend_valid ? ST_RELEASED : res_status;
      result_id    <= pend_valid ? r_id : res_id;
      released_pid <= pend_valid ? 4'(pend_pid) : 4'd0;
      last         <= 1'b1;
    end

    if (rst) begin
      slot_valid <= '0;
      live_count <= '0;
      next_id    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int k = 0; k < MAX_SEMAPHORES; k++) begin
        queue_head[k] <= '0;
        queue_fill[k] <= '0;
      end
    end else begin
      if (cmd.exec && r_action == ACT_CREATE &&
          live_count < LIVE_W'(MAX_SEMAPHORES) && free_hit) begin
        slot_valid[free_idx] <= 1'b1;
        live_count           <= live_count + LIVE_W'(1);
      end else if (cmd.exec && r_action == ACT_DESTROY && hit) begin
        slot_valid[hit_idx] <= 1'b0;
        if (live_count != '0) live_count <= live_count - LIVE_W'(1);
      end
      if (cmd.rel_step)  pend_valid <= 1'b1;
      else if (cmd.fin)  pend_valid <= 1'b0;
      if ((cmd.rel_step && pend_valid) || cmd.fin) out_valid <= 1'b1;
      else if (out_ready)                          out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    live_count == LIVE_W'($countones(slot_valid)))
    else $error("live count disagrees with valid slots");

  assert property (@(posedge clk) disable iff (rst)
    cmd.rel_rd |-> slot_valid[sel] && queue_fill[sel] != '0)
    else $error("queue read on empty or dead slot");

  assert property (@(posedge clk) disable iff (rst)
    cmd.rel_step |-> nrel < NRES_W'(MAX_RESULTS) && stat.covers)
    else $error("release beyond limit or uncovered");

  assert property (@(posedge clk) disable iff (rst)
    cmd.rel_step && pend_valid |-> out_free)
    else $error("release overwrote a waiting result");
endmodule
`default_nettype wire

@@ sv/counting_semaphore_unit.sv @@
`default_nettype none
// Counting semaphore table with per-semaphore FIFO wait queues.
// Channels: in_ch (sink) carries one action per transaction: create, destroy,
// get or give, with sem_id, amount, binary_mode and caller_pid. out_ch
// (source) carries result transactions; last marks the final one of an action.
// A transaction moves on a rising edge where valid and ready are both high.
// One action is worked at a time; in_ch.ready is high only while idle.
// Steps: an accepted action is latched, executed and then decided; the result
// of create, destroy, get, or a give that finds no positive count or an empty
// queue is then registered. A give that walks the queue releases waiters
// (possibly none), reading each head from the wait-queue memory with a
// registered read and then checking it. The walk stops at an empty queue, at
// the result limit or at a head the count does not cover. Each release is
// held until the next head is checked or the walk ends, so the last one
// carries the last flag.
// If out_ch stalls, one finished result waits in the output register and the
// block keeps going; it stops only when it needs that register again.
// Reset (rst, synchronous) empties the table, the queues and the id counter.
module counting_semaphore_unit
  import csu_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  csu_in_if.sink    in_ch,
  csu_out_if.source out_ch
);
  csu_cmd_t  cmd;
  csu_stat_t stat;
  logic      ready;

  assign in_ch.ready = ready;

  csu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (in_ch.action),
    .sem_id       (in_ch.sem_id),
    .amount       (in_ch.amount),
    .binary_mode  (in_ch.binary_mode),
    .caller_pid   (in_ch.caller_pid),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .result_id    (out_ch.result_id),
    .released_pid (out_ch.released_pid),
    .last         (out_ch.last)
  );
endmodule
`default_nettype wire
